FILE: rtl/core/jrg_pkg.sv
// ----------------------------------------------------------------------------
// jrg_pkg - shared types and constants for the Jacobi relaxation grid
// Default sizes, register map, reset values and the sequencer state type.
// ----------------------------------------------------------------------------
package jrg_pkg;

  // default sizing handed to the top level
  localparam int MAX_ROWS_DEF   = 8;
  localparam int MAX_COLS_DEF   = 8;
  localparam int VALUE_BITS_DEF = 16;

  // smallest usable grid edge (one interior cell)
  localparam int DIM_MIN = 3;

  // register widths fixed by the register map
  localparam int DIM_REG_BITS   = 4;
  localparam int SWEEP_REG_BITS = 16;
  localparam int APB_ADDR_BITS  = 4;
  localparam int APB_DATA_BITS  = 32;

  // register indexes (byte address is 4 * index)
  localparam logic [1:0] REG_ROW_COUNT   = 2'd0;
  localparam logic [1:0] REG_COL_COUNT   = 2'd1;
  localparam logic [1:0] REG_SWEEP_COUNT = 2'd2;

  // register reset values
  localparam logic [DIM_REG_BITS-1:0]   ROW_COUNT_RST   = 4'd8;
  localparam logic [DIM_REG_BITS-1:0]   COL_COUNT_RST   = 4'd8;
  localparam logic [SWEEP_REG_BITS-1:0] SWEEP_COUNT_RST = 16'd1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,      // taking cells from the input channel
    ST_SWEEP,     // five-phase stencil per interior cell
    ST_OUT_RD,    // address the result cell
    ST_OUT_CAP,   // capture RAM data into the output register
    ST_OUT_HOLD   // result presented, waiting for the sink
  } state_t;

  // stencil phases within one interior cell
  localparam logic [2:0] PH_UP    = 3'd0;
  localparam logic [2:0] PH_DOWN  = 3'd1;
  localparam logic [2:0] PH_LEFT  = 3'd2;
  localparam logic [2:0] PH_RIGHT = 3'd3;
  localparam logic [2:0] PH_WRITE = 3'd4;

endpackage

FILE: rtl/core/jacobi_relaxation_grid_top.sv
// ----------------------------------------------------------------------------
// jacobi_relaxation_grid_top - 2-D five-point Jacobi relaxation engine
// Loads a grid in raster order, runs the programmed number of sweeps with a
// single shared adder, then streams the relaxed grid out in raster order.
// Load: one cell per cycle, in_ready held high while loading.
// Sweep: each interior cell runs up, down, left, right and write phases, set by
//   the single RAM read port feeding four neighbour reads into one shared adder.
// Output: each cell is read from RAM, captured, then held until the sink takes it.
// Reset (synchronous, active low) returns to loading at cell zero; grid RAMs
//   are not cleared, as every cell read was written during the same load.
// ----------------------------------------------------------------------------
module jacobi_relaxation_grid_top
  import jrg_pkg::*;
#(
  parameter int MAX_ROWS   = MAX_ROWS_DEF,
  parameter int MAX_COLS   = MAX_COLS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input cells
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [VALUE_BITS-1:0] in_cell_in,
  // result cells
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [VALUE_BITS-1:0] out_cell_out,
  output logic                         out_last_cell,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [APB_ADDR_BITS-1:0]     paddr,
  input  logic [APB_DATA_BITS-1:0]     pwdata,
  output logic [APB_DATA_BITS-1:0]     prdata,
  output logic                         pready
);

  localparam int CELLS  = MAX_ROWS * MAX_COLS;
  localparam int AW     = $clog2(CELLS);
  localparam int PW     = $clog2(CELLS + 1);
  localparam int RW_RAW = ($clog2(MAX_ROWS + 1) > $clog2(MAX_COLS + 1)) ?
                          $clog2(MAX_ROWS + 1) : $clog2(MAX_COLS + 1);
  localparam int RW     = (RW_RAW > DIM_REG_BITS) ? RW_RAW : DIM_REG_BITS;
  localparam int SW     = VALUE_BITS + 2;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [DIM_REG_BITS-1:0]   row_count_r;
  logic [DIM_REG_BITS-1:0]   col_count_r;
  logic [SWEEP_REG_BITS-1:0] sweep_count_r;
  logic                      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r   <= ROW_COUNT_RST;
      col_count_r   <= COL_COUNT_RST;
      sweep_count_r <= SWEEP_COUNT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_ROW_COUNT:   row_count_r   <= pwdata[DIM_REG_BITS-1:0];
        REG_COL_COUNT:   col_count_r   <= pwdata[DIM_REG_BITS-1:0];
        REG_SWEEP_COUNT: sweep_count_r <= pwdata[SWEEP_REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    unique case (paddr[3:2])
      REG_ROW_COUNT:   prdata = APB_DATA_BITS'(row_count_r);
      REG_COL_COUNT:   prdata = APB_DATA_BITS'(col_count_r);
      REG_SWEEP_COUNT: prdata = APB_DATA_BITS'(sweep_count_r);
      default:         prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // grid dimensions, clamped to the supported range
  // --------------------------------------------------------------------------
  logic [RW-1:0] rows_ext, cols_ext;
  logic [RW-1:0] rows_c, cols_c;
  logic [PW-1:0] total;

  assign rows_ext = RW'(row_count_r);
  assign cols_ext = RW'(col_count_r);

  always_comb begin
    priority if (rows_ext < RW'(DIM_MIN)) rows_c = RW'(DIM_MIN);
    else if (rows_ext > RW'(MAX_ROWS))    rows_c = RW'(MAX_ROWS);
    else                                  rows_c = rows_ext;
    priority if (cols_ext < RW'(DIM_MIN)) cols_c = RW'(DIM_MIN);
    else if (cols_ext > RW'(MAX_COLS))    cols_c = RW'(MAX_COLS);
    else                                  cols_c = cols_ext;
  end

  assign total = PW'(PW'(rows_c) * PW'(cols_c));

  // --------------------------------------------------------------------------
  // sequencer and datapath registers
  // --------------------------------------------------------------------------
  state_t                    state_r, state_nxt;
  logic [PW-1:0]             load_pos_r, load_pos_nxt;
  logic [RW-1:0]             row_r, row_nxt;
  logic [RW-1:0]             col_r, col_nxt;
  logic [AW-1:0]             k_r, k_nxt;
  logic [2:0]                ph_r, ph_nxt;
  logic [SWEEP_REG_BITS-1:0] sweeps_r, sweeps_nxt;
  logic                      src_sel_r, src_sel_nxt;
  logic signed [SW-1:0]      acc_r, acc_nxt;
  logic [AW-1:0]             out_idx_r, out_idx_nxt;
  logic signed [VALUE_BITS-1:0] out_cell_r, out_cell_nxt;
  logic                      out_last_r, out_last_nxt;

  // RAM ports
  logic                         we_a, we_b;
  logic [AW-1:0]                waddr;
  logic [VALUE_BITS-1:0]        wdata;
  logic [AW-1:0]                raddr;
  logic [VALUE_BITS-1:0]        rdata_a, rdata_b, rdata;

  // shared adder and decode helpers
  logic signed [SW-1:0]         addend, sum;
  logic [AW-1:0]                cols_a;
  logic                         in_acc, out_acc;
  logic                         load_done, row_end, grid_end, sweeps_end;

  assign cols_a   = AW'(cols_c);
  assign in_acc   = in_valid & in_ready;
  assign out_acc  = out_valid & out_ready;
  assign rdata    = src_sel_r ? rdata_b : rdata_a;

  // one adder serves all four neighbour accumulations
  assign addend   = SW'(signed'(rdata));
  assign sum      = ((ph_r == PH_DOWN) ? '0 : acc_r) + addend;

  assign load_done  = (load_pos_r + PW'(1)) >= total;
  assign row_end    = (col_r == (cols_c - RW'(2)));
  assign grid_end   = row_end && (row_r == (rows_c - RW'(2)));
  assign sweeps_end = ((sweeps_r + SWEEP_REG_BITS'(1)) == sweep_count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      load_pos_r <= '0;
      sweeps_r   <= '0;
      src_sel_r  <= 1'b0;
      ph_r       <= PH_UP;
    end else begin
      state_r    <= state_nxt;
      load_pos_r <= load_pos_nxt;
      sweeps_r   <= sweeps_nxt;
      src_sel_r  <= src_sel_nxt;
      ph_r       <= ph_nxt;
    end
  end

  // payload and index registers
  always_ff @(posedge clk) begin
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    k_r        <= k_nxt;
    acc_r      <= acc_nxt;
    out_idx_r  <= out_idx_nxt;
    out_cell_r <= out_cell_nxt;
    out_last_r <= out_last_nxt;
  end

  // --------------------------------------------------------------------------
  // next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc && load_done) begin
          state_nxt = (sweep_count_r == '0) ? ST_OUT_RD : ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (ph_r == PH_WRITE && grid_end && sweeps_end) begin
          state_nxt = ST_OUT_RD;
        end
      end
      ST_OUT_RD:  state_nxt = ST_OUT_CAP;
      ST_OUT_CAP: state_nxt = ST_OUT_HOLD;
      ST_OUT_HOLD: begin
        if (out_ready) begin
          state_nxt = out_last_r ? ST_LOAD : ST_OUT_RD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // --------------------------------------------------------------------------
  // counters, adder and output capture
  // --------------------------------------------------------------------------
  always_comb begin
    load_pos_nxt = load_pos_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    k_nxt        = k_r;
    ph_nxt       = ph_r;
    sweeps_nxt   = sweeps_r;
    src_sel_nxt  = src_sel_r;
    acc_nxt      = acc_r;
    out_idx_nxt  = out_idx_r;
    out_cell_nxt = out_cell_r;
    out_last_nxt = out_last_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          load_pos_nxt = load_pos_r + PW'(1);
          if (load_done) begin
            // first interior cell of the first sweep
            row_nxt     = RW'(1);
            col_nxt     = RW'(1);
            k_nxt       = cols_a + AW'(1);
            ph_nxt      = PH_UP;
            sweeps_nxt  = '0;
            out_idx_nxt = '0;
          end
        end
      end
      ST_SWEEP: begin
        if (ph_r != PH_UP) begin
          acc_nxt = sum;
        end
        if (ph_r == PH_WRITE) begin
          ph_nxt = PH_UP;
          priority if (grid_end) begin
            // sweep finished: the freshly written buffer becomes current
            src_sel_nxt = ~src_sel_r;
            sweeps_nxt  = sweeps_r + SWEEP_REG_BITS'(1);
            row_nxt     = RW'(1);
            col_nxt     = RW'(1);
            k_nxt       = cols_a + AW'(1);
          end else if (row_end) begin
            // skip right border and left border of the next row
            row_nxt = row_r + RW'(1);
            col_nxt = RW'(1);
            k_nxt   = k_r + AW'(3);
          end else begin
            col_nxt = col_r + RW'(1);
            k_nxt   = k_r + AW'(1);
          end
        end else begin
          ph_nxt = ph_r + 3'd1;
        end
      end
      ST_OUT_RD: ;
      ST_OUT_CAP: begin
        out_cell_nxt = signed'(rdata);
        out_last_nxt = (PW'(out_idx_r) + PW'(1)) == total;
      end
      ST_OUT_HOLD: begin
        if (out_ready) begin
          if (out_last_r) begin
            load_pos_nxt = '0;
          end else begin
            out_idx_nxt = out_idx_r + AW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // outputs and RAM controls
  // --------------------------------------------------------------------------
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    we_a      = 1'b0;
    we_b      = 1'b0;
    waddr     = k_r;
    wdata     = sum[SW-1:2];
    raddr     = out_idx_r;
    unique case (state_r)
      ST_LOAD: begin
        // every cell lands in both buffers so borders stay in each
        in_ready = 1'b1;
        we_a     = in_acc;
        we_b     = in_acc;
        waddr    = load_pos_r[AW-1:0];
        wdata    = in_cell_in;
      end
      ST_SWEEP: begin
        unique case (ph_r)
          PH_UP:    raddr = k_r - cols_a;
          PH_DOWN:  raddr = k_r + cols_a;
          PH_LEFT:  raddr = k_r - AW'(1);
          PH_RIGHT: raddr = k_r + AW'(1);
          default:  raddr = k_r;
        endcase
        // floor of sum / 4 goes to the other buffer
        we_a = (ph_r == PH_WRITE) &&  src_sel_r;
        we_b = (ph_r == PH_WRITE) && !src_sel_r;
      end
      ST_OUT_RD:   ;
      ST_OUT_CAP:  ;
      ST_OUT_HOLD: out_valid = 1'b1;
      default: ;
    endcase
  end

  assign out_cell_out  = out_cell_r;
  assign out_last_cell = out_last_r;

  // --------------------------------------------------------------------------
  // grid buffers
  // --------------------------------------------------------------------------
  jrg_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (CELLS)
  ) u_grid_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_a)
  );

  jrg_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (CELLS)
  ) u_grid_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_b)
  );

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // no new cell taken while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("input accepted while a result is pending");

  // load pointer stays within the grid store; a size shrunk mid-load may
  // leave it at or past the current grid size until the next cell arrives
  a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |-> (load_pos_r < PW'(CELLS)))
    else $error("load position past grid store");

  // sweeping only while sweeps remain
  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP) |-> (sweeps_r < sweep_count_r) && (ph_r <= PH_WRITE))
    else $error("sweep counter or phase out of range");

  // delivering the last cell reopens the input
  a_last_reload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_last_cell) |=> (in_ready && (load_pos_r == '0)))
    else $error("loading did not restart after the last cell");

endmodule

FILE: rtl/core/jrg_ram.sv
// ----------------------------------------------------------------------------
// jrg_ram - generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module jrg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: tb/jacobi_relaxation_grid_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// jacobi_relaxation_grid_top_test - self-checking bench for the relaxation grid
// Loads grids over the request channel, programs size and sweep count through
// the register port (once mid-grid), and checks every streamed cell and its
// last-cell mark against a local five-point stencil predictor. A short scripted
// part covers extremes and corner behaviour, then random grids run under three
// handshake idling regimes, including one long sink hold-off.
// ----------------------------------------------------------------------------
module jacobi_relaxation_grid_top_test;
  import jrg_pkg::*;

  localparam int     VB           = VALUE_BITS_DEF;
  localparam int     GRID_CELLS   = MAX_ROWS_DEF * MAX_COLS_DEF;
  localparam int     RANDOM_REQS  = 150;
  localparam int     SETTLE       = 8;
  localparam int     LONG_HOLD    = 400;
  localparam longint CYCLE_LIMIT  = 2000000;
  localparam int     SCRIPT_ROWS  = 40;
  // index past the register map, writes to it must be dropped
  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef logic signed [VB-1:0] q88_t;

  typedef struct {
    q88_t val;
    logic is_last;
  } relaxed_cell_t;

  typedef enum logic [1:0] {RK_REG, RK_CELL} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  idx;
    logic [15:0] data;
    logic        chk;   // centre of a 3x3 grid typed in below
    logic [15:0] mid;
  } script_row_t;

  // DUT connections
  logic                     clk       = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  q88_t                     in_cell_in = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  q88_t                     out_cell_out;
  logic                     out_last_cell;
  logic                     psel      = 1'b0;
  logic                     penable   = 1'b0;
  logic                     pwrite    = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr     = '0;
  logic [APB_DATA_BITS-1:0] pwdata    = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  // typed centre value travelling with the request
  logic tag_on  = 1'b0;
  q88_t tag_mid = '0;

  // idling control
  int send_idle_pct = 20;
  int recv_idle_pct = 83;
  int hold_asked    = 0;
  int hold_seen     = 0;
  int hold_left     = 0;

  // predictor state
  q88_t                   held [GRID_CELLS];
  int unsigned            held_n     = 0;
  logic [DIM_REG_BITS-1:0]   rows_reg   = ROW_COUNT_RST;
  logic [DIM_REG_BITS-1:0]   cols_reg   = COL_COUNT_RST;
  logic [SWEEP_REG_BITS-1:0] sweeps_reg = SWEEP_COUNT_RST;
  relaxed_cell_t          relaxed_q [$];

  // bookkeeping
  longint cycles     = 0;
  int     mismatches = 0;
  int     reqs_in    = 0;
  int     cells_out  = 0;
  int     grids_out  = 0;
  int     top_sweeps = 0;

  // directed script: extremes, clamped sizes, zero and maximum sweeps,
  // dropped spare write, and a shrink while a grid is partly loaded
  script_row_t script [0:SCRIPT_ROWS-1] = '{
    // 3x3, no sweeps: grid comes back as loaded
    '{RK_REG,  REG_ROW_COUNT,   16'd3,     1'b0, 16'h0000},
    '{RK_REG,  REG_COL_COUNT,   16'd3,     1'b0, 16'h0000},
    '{RK_REG,  REG_SWEEP_COUNT, 16'd0,     1'b0, 16'h0000},
    '{RK_CELL, 2'd0,            16'h7FFF,  1'b0, 16'h0000},
    '{RK_CELL, 2'd0,            16'h8000,  1'b0, 16'h0000},
    '{RK_CELL, 2'd0,            16'h0001,  1'b0, 16'h0000},
    '{RK_CELL, 2'd0,            16'hFFFF,  1'b0, 16'h0000},
    '{RK_CELL, 2'd0,            16'h8000,  1'b0, 16'h0000},
    '{RK_CELL, 2'd0,            16'h0000,  1'b0, 16'h0000},
    '{RK_CELL, 2'd0,            16'h0100,  1'b0, 16'h0000},
    '{RK_CELL, 2'd0,            16'h7FFF,  1'b0, 16'h0000},
    '{RK_CELL, 2'd0,            16'h8000,  1'b1, 16'h8000},
    // sizes below minimum run as 3x3, full sweep count; neighbours sum to -2,
    // so the centre floors to -1
    '{RK_REG,  REG_ROW_COUNT,   16'd2,     1'b0, 16'h0000},
    '{RK_REG,  REG_COL_COUNT,   16'd0,     1'b0, 16'h0000},
    '{RK_REG,  REG_SWEEP_COUNT, 16'hFFFF,  1'b0, 16'h0000},
    '{RK_CELL, 2'd0,            16'h0000,  1'b0, 16'h0000},
    '{RK_CELL, 2'd0,            16'h8000,  1'b0, 16'h0000},
    '{RK_CELL, 2'd0,            16'h0000,  1'b0, 16'h0000},
    '{RK_CELL, 2'd0,            16'h7FFF,  1'b0, 16'h0000},
    '{RK_CELL, 2'd0,            16'h3039,  1'b0, 16'h0000},
    '{RK_CELL, 2'd0,            16'h8000,  1'b0, 16'h0000},
    '{RK_CELL, 2'd0,            16'h0000,  1'b0, 16'h0000},
    '{RK_CELL, 2'd0,            16'h7FFF,  1'b0, 16'h0000},
    '{RK_CELL, 2'd0,            16'h0000,  1'b1, 16'hFFFF},
    // sizes above maximum run as 8x8; spare register write is ignored
    '{RK_REG,  REG_ROW_COUNT,   16'd15,    1'b0, 16'h0000},
    '{RK_REG,  REG_COL_COUNT,   16'd9,     1'b0, 16'h0000},
    '{RK_REG,  REG_SWEEP_COUNT, 16'd1,     1'b0, 16'h0000},
    '{RK_REG,  REG_SPARE,       16'hFFFF,  1'b0, 16'h0000},
    '{RK_CELL, 2'd0,            16'h0064,  1'b0, 16'h0000},  // 100
    '{RK_CELL, 2'd0,            16'hFF38,  1'b0, 16'h0000},  // -200
    '{RK_CELL, 2'd0,            16'h012C,  1'b0, 16'h0000},  // 300
    '{RK_CELL, 2'd0,            16'hFE70,  1'b0, 16'h0000},  // -400
    '{RK_CELL, 2'd0,            16'h01F4,  1'b0, 16'h0000},  // 500
    '{RK_CELL, 2'd0,            16'hFDA8,  1'b0, 16'h0000},  // -600
    '{RK_CELL, 2'd0,            16'h02BC,  1'b0, 16'h0000},  // 700
    '{RK_CELL, 2'd0,            16'hFCE0,  1'b0, 16'h0000},  // -800
    '{RK_CELL, 2'd0,            16'h0384,  1'b0, 16'h0000},  // 900
    // shrink to 3x3 with nine cells held; next cell fires on the first nine
    '{RK_REG,  REG_ROW_COUNT,   16'd1,     1'b0, 16'h0000},
    '{RK_REG,  REG_COL_COUNT,   16'd2,     1'b0, 16'h0000},
    '{RK_CELL, 2'd0,            16'h03E8,  1'b1, 16'hFE0C}   // centre -500
  };

  jacobi_relaxation_grid_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cell_in    (in_cell_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_cell_out  (out_cell_out),
    .out_last_cell (out_last_cell),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk = ~clk;

  // clamp a programmed edge length to the usable range
  function automatic int unsigned fit_edge(input logic [DIM_REG_BITS-1:0] v,
                                           input int unsigned hi);
    if (v < DIM_MIN) return DIM_MIN;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [DIM_REG_BITS-1:0] pick_edge();
    if ($urandom_range(0, 3) == 0) return DIM_REG_BITS'($urandom_range(0, 15));
    return DIM_REG_BITS'($urandom_range(3, 8));
  endfunction

  // run the programmed sweeps over the held grid and queue the raster output
  task automatic relax_grid(input int unsigned rows, input int unsigned cols,
                            input logic chk_on, input q88_t chk_mid);
    q88_t                 now_g [GRID_CELLS];
    q88_t                 nxt_g [GRID_CELLS];
    logic signed [VB+1:0] sum;
    logic                 moved;
    int unsigned          s, r, c, k;
    relaxed_cell_t        res;
    now_g = held;
    if (sweeps_reg > top_sweeps) top_sweeps = sweeps_reg;
    for (s = 0; s < sweeps_reg; s++) begin
      nxt_g = now_g;
      moved = 1'b0;
      for (r = 1; r + 1 < rows; r++) begin
        for (c = 1; c + 1 < cols; c++) begin
          k = r * cols + c;
          sum = now_g[k - cols];
          sum = sum + now_g[k + cols];
          sum = sum + now_g[k - 1];
          sum = sum + now_g[k + 1];
          nxt_g[k] = q88_t'(sum >>> 2);
          if (nxt_g[k] !== now_g[k]) moved = 1'b1;
        end
      end
      now_g = nxt_g;
      // a settled grid stays settled, remaining sweeps change nothing
      if (!moved) break;
    end
    for (k = 0; k < rows * cols; k++) begin
      res.val     = now_g[k];
      res.is_last = (k + 1 == rows * cols);
      if (chk_on && rows * cols == 9 && k == 4) res.val = chk_mid;
      relaxed_q.push_back(res);
    end
  endtask

  task automatic note_miss(input string what);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH at cycle %0d: %s", cycles, what);
  endtask

  // cycle count and watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Watchdog expired after %0d cycles, %0d cells outstanding",
               cycles, relaxed_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // sink: random stalls, plus one long hold-off when asked
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_asked) begin
      hold_seen <= hold_asked;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // watch register writes, accepted requests and results
  always @(posedge clk) begin : watch
    int unsigned   rows, cols;
    relaxed_cell_t want;
    if (rst_n) begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[APB_ADDR_BITS-1:2])
          REG_ROW_COUNT:   rows_reg   = pwdata[DIM_REG_BITS-1:0];
          REG_COL_COUNT:   cols_reg   = pwdata[DIM_REG_BITS-1:0];
          REG_SWEEP_COUNT: sweeps_reg = pwdata[SWEEP_REG_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        reqs_in++;
        if (held_n < GRID_CELLS) begin
          held[held_n] = in_cell_in;
          held_n++;
        end
        rows = fit_edge(rows_reg, MAX_ROWS_DEF);
        cols = fit_edge(cols_reg, MAX_COLS_DEF);
        if (held_n >= rows * cols) begin
          relax_grid(rows, cols, tag_on, tag_mid);
          held_n = 0;
        end
      end
      if (out_valid && out_ready) begin
        cells_out++;
        if (out_last_cell) grids_out++;
        if (relaxed_q.size() == 0) begin
          note_miss($sformatf("unrequested cell %0d last %0b",
                              out_cell_out, out_last_cell));
        end else begin
          want = relaxed_q.pop_front();
          if (out_cell_out !== want.val || out_last_cell !== want.is_last)
            note_miss($sformatf("cell exp %0d got %0d, last exp %0b got %0b",
                                want.val, out_cell_out, want.is_last, out_last_cell));
        end
      end
    end
  end

  // offer one cell; valid stays up after acceptance unless a gap follows
  task automatic push_cell(input q88_t v, input logic chk_on, input q88_t chk_mid);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_cell_in <= v;
    tag_on     <= chk_on;
    tag_mid    <= chk_mid;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // setup then access phase, then the bus returns to idle
  task automatic write_reg(input logic [1:0] idx, input logic [APB_DATA_BITS-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // stop offering and wait until every predicted cell has come out
  task automatic wait_drained;
    in_valid <= 1'b0;
    @(posedge clk);
    while (relaxed_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin : stimulus
    int                        phase, phase_reqs, g, n_grids, j;
    int unsigned               r_eff, c_eff;
    logic [DIM_REG_BITS-1:0]   rows_w, cols_w;
    int                        sweeps_w;
    logic                      squeeze, squeezed;
    q88_t                      v;
    squeezed = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // scripted part
    foreach (script[i]) begin
      if (script[i].kind == RK_REG) begin
        wait_drained();
        write_reg(script[i].idx, APB_DATA_BITS'(script[i].data));
      end else begin
        push_cell(q88_t'(script[i].data), script[i].chk, q88_t'(script[i].mid));
      end
    end

    // random grids under three idling regimes
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct <= 20;
          recv_idle_pct <= 83;
        end
        1: begin
          send_idle_pct <= 83;
          recv_idle_pct <= 20;
        end
        default: begin
          send_idle_pct <= 0;
          recv_idle_pct <= 0;
        end
      endcase
      phase_reqs = 0;
      while (phase_reqs < RANDOM_REQS / 3) begin
        rows_w = pick_edge();
        cols_w = pick_edge();
        r_eff  = fit_edge(rows_w, MAX_ROWS_DEF);
        c_eff  = fit_edge(cols_w, MAX_COLS_DEF);
        case ($urandom_range(0, 9))
          0, 1: sweeps_w = 0;
          8: sweeps_w = $urandom_range(7, 40);
          9: sweeps_w = ((r_eff - 2) * (c_eff - 2) <= 4) ? $urandom_range(41, 300)
                                                          : $urandom_range(7, 40);
          default: sweeps_w = $urandom_range(1, 6);
        endcase
        wait_drained();
        write_reg(REG_ROW_COUNT, APB_DATA_BITS'(rows_w));
        write_reg(REG_COL_COUNT, APB_DATA_BITS'(cols_w));
        write_reg(REG_SWEEP_COUNT, APB_DATA_BITS'(sweeps_w));
        // once, hold the sink off while the next grid is being offered
        squeeze = (phase == 2) && !squeezed;
        n_grids = squeeze ? 2 : $urandom_range(1, 2);
        for (g = 0; g < n_grids; g++) begin
          for (j = 0; j < r_eff * c_eff; j++) begin
            case ($urandom_range(0, 9))
              0: v = 16'sh7FFF;
              1: v = 16'sh8000;
              2, 3: v = q88_t'(int'($urandom_range(0, 16)) - 8);
              default: v = q88_t'($urandom);
            endcase
            push_cell(v, 1'b0, '0);
          end
          phase_reqs += r_eff * c_eff;
          if (squeeze && g == 0) begin
            hold_asked <= hold_asked + 1;
            squeezed = 1'b1;
          end
        end
      end
    end

    wait_drained();
    $display("Ran %0d grids: %0d cells loaded, %0d relaxed cells checked", grids_out,
             reqs_in, cells_out);
    $display("Sizes 3x3 to 8x8 incl. clamped settings, up to %0d sweeps; %0d mismatches",
             top_sweeps, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
